>>> hw/rtl/grid_bearing_angle_defines.svh
// Assertion macros used by the checker of the grid bearing block.
`ifndef GRID_BEARING_ANGLE_DEFINES_SVH
`define GRID_BEARING_ANGLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define GBA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid_bearing_angle: assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define GBA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid_bearing_angle: assertion failed");

`endif

>>> hw/rtl/gba_pkg.sv
// Package with widths, constants, stage types and the arctangent table of the bearing block.
`timescale 1ns / 1ps
`default_nettype none

package gba_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 24;
  localparam int ANG_FRAC     = 20;
  localparam int TABLE_LEN    = 24;

  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int DATA_W    = COORD_WIDTH + GUARD_BITS + 4;
  localparam int ACC_W     = 30;
  localparam int BEAR_W    = 17;
  localparam int TAB_IDX_W = $clog2(TABLE_LEN);

  localparam logic signed [ACC_W-1:0] HALF_TURN_ACC = ACC_W'(180 * (2 ** ANG_FRAC));
  localparam logic signed [ACC_W-1:0] FULL_TURN_ACC = ACC_W'(360 * (2 ** ANG_FRAC));
  localparam logic signed [ACC_W-1:0] ROUND_ACC     = ACC_W'(2 ** (ANG_FRAC - 9));
  localparam logic [BEAR_W-1:0]       FULL_TURN_OUT = BEAR_W'(92160);
  localparam logic [BEAR_W-1:0]       HALF_TURN_OUT = BEAR_W'(46080);

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [ACC_W-1:0]  acc;
    logic                     vert;
    logic                     vert_half;
  } cordic_t;

  function automatic logic signed [ACC_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] v;
    unique case (idx)
      5'd0:    v = ACC_W'(47185920);
      5'd1:    v = ACC_W'(27855475);
      5'd2:    v = ACC_W'(14718068);
      5'd3:    v = ACC_W'(7471121);
      5'd4:    v = ACC_W'(3750058);
      5'd5:    v = ACC_W'(1876857);
      5'd6:    v = ACC_W'(938658);
      5'd7:    v = ACC_W'(469357);
      5'd8:    v = ACC_W'(234682);
      5'd9:    v = ACC_W'(117342);
      5'd10:   v = ACC_W'(58671);
      5'd11:   v = ACC_W'(29335);
      5'd12:   v = ACC_W'(14668);
      5'd13:   v = ACC_W'(7334);
      5'd14:   v = ACC_W'(3667);
      5'd15:   v = ACC_W'(1833);
      5'd16:   v = ACC_W'(917);
      5'd17:   v = ACC_W'(458);
      5'd18:   v = ACC_W'(229);
      5'd19:   v = ACC_W'(115);
      5'd20:   v = ACC_W'(57);
      5'd21:   v = ACC_W'(29);
      5'd22:   v = ACC_W'(14);
      5'd23:   v = ACC_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gba_if.sv
// Valid/ready channel interfaces for point pairs and bearing results.
`timescale 1ns / 1ps
`default_nettype none

interface gba_in_if;
  import gba_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface gba_out_if;
  import gba_pkg::*;
  logic              valid;
  logic              ready;
  logic [BEAR_W-1:0] bearing;

  modport source (output valid, bearing, input ready);
  modport sink (input valid, bearing, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gba_prep.sv
// Front end: coordinate differences, half-plane fold and CORDIC start vector.
`timescale 1ns / 1ps
`default_nettype none

module gba_prep
  import gba_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_v,
  input  wire logic signed [COORD_WIDTH-1:0] first_x,
  input  wire logic signed [COORD_WIDTH-1:0] first_y,
  input  wire logic signed [COORD_WIDTH-1:0] second_x,
  input  wire logic signed [COORD_WIDTH-1:0] second_y,
  output logic                               out_v,
  output cordic_t                            out_d
);

  logic                     diff_v;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dz;
  logic signed [DIFF_W-1:0] dx_f;
  logic signed [DIFF_W-1:0] dz_f;
  logic                     left;
  cordic_t                  start_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_v <= 1'b0;
      out_v  <= 1'b0;
    end else if (en) begin
      diff_v <= in_v;
      out_v  <= diff_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx    <= DIFF_W'(first_x) - DIFF_W'(second_x);
      dz    <= DIFF_W'(first_y) - DIFF_W'(second_y);
      out_d <= start_next;
    end
  end

  always_comb begin
    left                 = dz[DIFF_W-1];
    dx_f                 = left ? -dx : dx;
    dz_f                 = left ? -dz : dz;
    start_next.x         = DATA_W'(dz_f) <<< GUARD_BITS;
    start_next.y         = DATA_W'(dx_f) <<< GUARD_BITS;
    start_next.acc       = left ? HALF_TURN_ACC : '0;
    start_next.vert      = (dx == '0);
    start_next.vert_half = left || (dz == '0);
  end

endmodule

`default_nettype wire

>>> hw/rtl/gba_cell.sv
// One CORDIC vectoring cell: a rotation step with its own output register.
`timescale 1ns / 1ps
`default_nettype none

module gba_cell
  import gba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic [TAB_IDX_W-1:0] idx,
  input  wire logic                 in_v,
  input  wire cordic_t              in_d,
  output logic                      out_v,
  output cordic_t                   out_d
);

  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  logic signed [ACC_W-1:0]  ang;
  cordic_t                  out_next;

  always_comb begin
    xs       = in_d.x >>> idx;
    ys       = in_d.y >>> idx;
    ang      = atan_deg(idx);
    out_next = in_d;
    if (!in_d.y[DATA_W-1]) begin
      out_next.x   = in_d.x + ys;
      out_next.y   = in_d.y - xs;
      out_next.acc = in_d.acc + ang;
    end else begin
      out_next.x   = in_d.x - ys;
      out_next.y   = in_d.y + xs;
      out_next.acc = in_d.acc - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= out_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gba_post.sv
// Back end: wrap and rounding of the angle, then output register with skid buffer.
`timescale 1ns / 1ps
`default_nettype none

module gba_post
  import gba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  output logic          en,
  input  wire logic     in_v,
  input  wire cordic_t  in_d,
  gba_out_if.source     result
);

  logic signed [ACC_W-1:0] sum;
  logic [BEAR_W-1:0]       rnd_next;
  logic                    rnd_v;
  logic [BEAR_W-1:0]       rnd;
  logic [BEAR_W-1:0]       wrapped;
  logic                    out_v;
  logic [BEAR_W-1:0]       out_data;
  logic                    skid_v;
  logic [BEAR_W-1:0]       skid_data;

  assign en = !skid_v;

  always_comb begin
    sum = in_d.acc + (in_d.acc[ACC_W-1] ? FULL_TURN_ACC : '0) + ROUND_ACC;
    if (in_d.vert) begin
      rnd_next = in_d.vert_half ? HALF_TURN_OUT : '0;
    end else begin
      rnd_next = sum[ANG_FRAC-8 +: BEAR_W];
    end
    wrapped = (rnd >= FULL_TURN_OUT) ? rnd - FULL_TURN_OUT : rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_v <= 1'b0;
    end else if (en) begin
      rnd_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd <= rnd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || result.ready) begin
      if (skid_v) begin
        out_v    <= 1'b1;
        out_data <= skid_data;
        skid_v   <= 1'b0;
      end else begin
        out_v    <= rnd_v;
        out_data <= wrapped;
      end
    end else if (rnd_v && !skid_v) begin
      skid_v    <= 1'b1;
      skid_data <= wrapped;
    end
  end

  assign result.valid   = out_v;
  assign result.bearing = out_data;

endmodule

`default_nettype wire

>>> hw/rtl/grid_bearing_angle.sv
// Stages from input transfer to result: two in the front end, one per CORDIC cell and two
// in the back end (rounding, then the output register).
// Throughput: one point pair per cycle while ready is high; each CORDIC cell holds one item.
// A full skid register lowers ready until the held result is taken.
// Reset clears all valid bits, the skid flag among them; data registers keep their contents.
`timescale 1ns / 1ps
`default_nettype none

module grid_bearing_angle
  import gba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  gba_in_if.sink    points,
  gba_out_if.source result
);

  logic    en;
  logic    stage_v [0:CORDIC_STEPS];
  cordic_t stage_d [0:CORDIC_STEPS];

  assign points.ready = en;

  gba_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (points.valid),
    .first_x  (points.first_x),
    .first_y  (points.first_y),
    .second_x (points.second_x),
    .second_y (points.second_y),
    .out_v    (stage_v[0]),
    .out_d    (stage_d[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    gba_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .idx   (TAB_IDX_W'(g)),
      .in_v  (stage_v[g]),
      .in_d  (stage_d[g]),
      .out_v (stage_v[g+1]),
      .out_d (stage_d[g+1])
    );
  end

  gba_post u_post (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (stage_v[CORDIC_STEPS]),
    .in_d   (stage_d[CORDIC_STEPS]),
    .result (result)
  );

endmodule

`default_nettype wire

>>> hw/rtl/gba_checker.sv
// Port-level checker for the bearing block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_bearing_angle_defines.svh"

module gba_checker
  import gba_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BEAR_W-1:0] bearing
);

  `GBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bearing))
  `GBA_ASSERT_IMPL(a_bearing_range, out_valid, bearing < FULL_TURN_OUT)
  `GBA_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready)
  `GBA_ASSERT_IMPL(a_stall_cause, !in_ready, $past(out_valid && !out_ready))
  `GBA_ASSERT_IMPL(a_empty_after_reset, $past(rst), !out_valid && !(in_valid && !in_ready))

endmodule

bind grid_bearing_angle gba_checker u_gba_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (points.valid),
  .in_ready  (points.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .bearing   (result.bearing)
);

`default_nettype wire
